// File: rtl/kar_pkg.sv
// shared types and constants for the keypad auto-repeat fifo core
// no dependencies; imported by every module under rtl
`timescale 1ns / 1ps

package kar_pkg;

	localparam int FIFO_DEPTH = 256;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int MAX_READ   = 64;
	localparam int RC_W       = 7;
	localparam int FILL_W     = 9;
	localparam int CODE_W     = 3;
	localparam int DELAY_W    = 8;
	localparam int BYTE_W     = 8;
	localparam int IDX_W      = 2;

	localparam logic [BYTE_W-1:0]  ASCII_ZERO  = 8'd48;
	localparam logic [DELAY_W-1:0] LONG_RESET  = 8'd70;
	localparam logic [DELAY_W-1:0] SHORT_RESET = 8'd10;

	typedef enum logic [1:0] {
		OP_EDGE = 2'd0,
		OP_TICK = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_e_t;

	typedef enum logic [IDX_W-1:0] {
		REG_LONG_DELAY    = 2'd0,
		REG_SHORT_DELAY   = 2'd1,
		REG_REPEAT_ENABLE = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_NOP  = 2'd0,
		CMD_PUSH = 2'd1,
		CMD_READ = 2'd2
	} cmd_kind_t;

	// one classified request from the front to the back
	typedef struct packed {
		cmd_kind_t         kind;
		logic [BYTE_W-1:0] data;
		logic [RC_W-1:0]   cnt;
	} cmd_t;

	// result flags that travel beside the popped byte
	typedef struct packed {
		logic              byte_valid;
		logic              last;
		logic [FILL_W-1:0] fill;
		logic              dropped;
	} res_t;

endpackage

// File: rtl/kar_front.sv
// front end: config registers, switch code and repeat countdown
// classifies each request into a fifo command; uses kar_pkg
`timescale 1ns / 1ps

module kar_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr,
	input  logic [kar_pkg::IDX_W-1:0]  cfg_index,
	input  logic [kar_pkg::DELAY_W-1:0] cfg_data,
	input  logic                       in_accept,
	input  logic [1:0]                 op,
	input  logic [kar_pkg::CODE_W-1:0] switch_levels,
	input  logic [kar_pkg::RC_W-1:0]   read_count,
	output kar_pkg::cmd_t              cmd
);
	import kar_pkg::*;

	logic [DELAY_W-1:0] long_delay_q;
	logic [DELAY_W-1:0] short_delay_q;
	logic               repeat_enable_q;
	logic [DELAY_W-1:0] ticks_q, ticks_d;
	logic [CODE_W-1:0]  cur_q, cur_d;
	logic [CODE_W-1:0]  prev_q, prev_d;

	always_comb begin
		cur_d    = cur_q;
		prev_d   = prev_q;
		ticks_d  = ticks_q;
		cmd.kind = CMD_NOP;
		cmd.cnt  = '0;
		unique case (op_e_t'(op))
			OP_EDGE: begin
				cur_d    = ~switch_levels;
				cmd.kind = CMD_PUSH;
			end
			OP_TICK: begin
				if (repeat_enable_q) begin
					if (ticks_q <= DELAY_W'(1)) begin
						if (prev_q != cur_q) begin
							ticks_d = long_delay_q;
						end else begin
							ticks_d = short_delay_q;
							if (cur_q != '0) cmd.kind = CMD_PUSH;
						end
						prev_d = cur_q;
					end else begin
						ticks_d = ticks_q - DELAY_W'(1);
					end
				end
			end
			OP_READ: begin
				cmd.kind = CMD_READ;
				cmd.cnt  = (read_count > RC_W'(MAX_READ)) ? RC_W'(MAX_READ) : read_count;
			end
			default: cmd.kind = CMD_NOP;
		endcase
		cmd.data = ASCII_ZERO + {{(BYTE_W-CODE_W){1'b0}}, cur_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_delay_q    <= LONG_RESET;
			short_delay_q   <= SHORT_RESET;
			repeat_enable_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LONG_DELAY:    long_delay_q    <= cfg_data;
				REG_SHORT_DELAY:   short_delay_q   <= cfg_data;
				REG_REPEAT_ENABLE: repeat_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= LONG_RESET;
			cur_q   <= '0;
			prev_q  <= '0;
		end else if (in_accept) begin
			ticks_q <= ticks_d;
			cur_q   <= cur_d;
			prev_q  <= prev_d;
		end
	end

endmodule

// File: rtl/kar_cmd_queue.sv
// two-entry command queue between front and back
// uses kar_pkg for the command type
`timescale 1ns / 1ps

module kar_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kar_pkg::cmd_t push_cmd,
	output logic          ready,
	input  logic          pop,
	output logic          valid,
	output kar_pkg::cmd_t head
);
	import kar_pkg::*;

	cmd_t       entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign ready   = (count_q != 2'd2);
	assign valid   = (count_q != 2'd0);
	assign head    = entries_q[rd_ptr_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) entries_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/kar_back.sv
// back end: byte fifo storage, pointers, read sequencing and output register
// consumes commands from kar_cmd_queue; uses kar_pkg
`timescale 1ns / 1ps

module kar_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  kar_pkg::cmd_t              cmd,
	output logic                       cmd_pop,
	output logic                       res_valid,
	input  logic                       res_ready,
	output kar_pkg::res_t              res,
	output logic [kar_pkg::BYTE_W-1:0] data_byte
);
	import kar_pkg::*;

	logic [BYTE_W-1:0] mem [FIFO_DEPTH];
	logic [BYTE_W-1:0] rdata_q;
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  held_q, held_d;
	logic              rd_active_q;
	logic [RC_W-1:0]   left_q;
	logic [RC_W-1:0]   rem;
	logic              res_valid_s2;
	res_t              res_s2, res_d;
	logic              s2_ready;
	logic              issue;
	logic              do_push;
	logic              do_pop;
	logic              full;

	assign s2_ready = !res_valid_s2 || res_ready;
	assign issue    = cmd_valid && s2_ready;
	assign full     = (held_q == CNT_W'(FIFO_DEPTH));

	always_comb begin
		do_push = 1'b0;
		do_pop  = 1'b0;
		cmd_pop = 1'b0;
		held_d  = held_q;
		rem     = '0;
		res_d   = '{byte_valid: 1'b0, last: 1'b1, fill: '0, dropped: 1'b0};
		unique case (cmd.kind)
			CMD_PUSH: begin
				do_push       = !full;
				res_d.dropped = full;
				cmd_pop       = 1'b1;
				if (!full) held_d = held_q + CNT_W'(1);
			end
			CMD_READ: begin
				// first byte sizes the burst, later bytes count down
				if (rd_active_q) begin
					rem = left_q;
				end else if (CNT_W'(cmd.cnt) < held_q) begin
					rem = cmd.cnt;
				end else begin
					rem = RC_W'(held_q);
				end
				if (rem == '0) begin
					cmd_pop = 1'b1;
				end else begin
					do_pop           = 1'b1;
					res_d.byte_valid = 1'b1;
					res_d.last       = (rem == RC_W'(1));
					cmd_pop          = res_d.last;
					held_d           = held_q - CNT_W'(1);
				end
			end
			default: cmd_pop = 1'b1;
		endcase
		res_d.fill = FILL_W'(held_d);
		if (!issue) begin
			do_push = 1'b0;
			do_pop  = 1'b0;
			cmd_pop = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem[wr_q] <= cmd.data;
		if (do_pop) rdata_q <= mem[rd_q];
	end

	always_ff @(posedge clk) begin
		if (issue) res_s2 <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q         <= '0;
			rd_q         <= '0;
			held_q       <= '0;
			rd_active_q  <= 1'b0;
			left_q       <= '0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (issue) begin
				held_q       <= held_d;
				rd_active_q  <= do_pop && !cmd_pop;
				left_q       <= rem - RC_W'(1);
				res_valid_s2 <= 1'b1;
			end else if (res_ready) begin
				res_valid_s2 <= 1'b0;
			end
			if (do_push) wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (do_pop) rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
		end
	end

	assign res_valid = res_valid_s2;
	assign res       = res_s2;
	assign data_byte = res_s2.byte_valid ? rdata_q : '0;

`ifndef SYNTHESIS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(FIFO_DEPTH))
		else $error("fifo count above depth");
	a_burst_head: assert property (@(posedge clk) disable iff (!arst_n)
		rd_active_q |-> (cmd_valid && cmd.kind == CMD_READ && left_q != '0))
		else $error("read burst without read command at head");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |-> (held_q != '0))
		else $error("pop from empty fifo");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> (held_q == $past(held_q) + CNT_W'(1)))
		else $error("push did not raise fifo count");
`endif

endmodule

// File: rtl/keypad_auto_repeat_fifo_core.sv
// top level of the keypad auto-repeat fifo core
// instantiates kar_front, kar_cmd_queue and kar_back; uses kar_pkg
`timescale 1ns / 1ps

// keypad auto-repeat fifo: a request is a switch edge, a timer tick or a
// read (tuser). a switch edge stores '0'+code of the inverted switch levels
// in a 256-byte fifo; ticks run a typematic countdown that reloads with
// long_delay after a code change and with short_delay plus a repeat push
// while a nonzero code holds. a read pops up to min(read_count, 64) bytes,
// one result per byte with tlast on the final one; edges, ticks and empty
// reads give one result with tuser low. requests are taken one per clock
// if the queue has room, even while a result waits; a read delivers one byte
// per clock unless stalled, paced by the single read port of the byte memory,
// and holds later requests in the two-entry command queue until its last byte
// is issued. results pass through one output register. the byte memory is
// not cleared at reset and needs no clearing pass; only written entries are
// ever popped. config writes (cfg_index 0 long_delay, 1 short_delay,
// 2 repeat_enable) are always taken and belong in idle periods only.
module keypad_auto_repeat_fifo_core (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // switch_levels[2:0], read_count[9:3], zero pad
	input  logic [1:0]  s_axis_tuser,  // op[1:0]
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // data_byte[7:0], fill_level[16:8], dropped[17], zero pad
	output logic        m_axis_tuser,  // byte_valid
	output logic        m_axis_tlast
);
	import kar_pkg::*;

	cmd_t              front_cmd;
	cmd_t              head_cmd;
	logic              q_ready;
	logic              q_valid;
	logic              q_pop;
	logic              in_accept;
	res_t              res;
	logic [BYTE_W-1:0] data_byte;

	// config is always accepted
	assign cfg_ready     = 1'b1;
	assign s_axis_tready = q_ready;
	assign in_accept     = s_axis_tvalid && q_ready;

	kar_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_accept     (in_accept),
		.op            (s_axis_tuser),
		.switch_levels (s_axis_tdata[2:0]),
		.read_count    (s_axis_tdata[9:3]),
		.cmd           (front_cmd)
	);

	// decouples request classification from fifo access
	kar_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s_axis_tvalid),
		.push_cmd (front_cmd),
		.ready    (q_ready),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (head_cmd)
	);

	kar_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (head_cmd),
		.cmd_pop   (q_pop),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res),
		.data_byte (data_byte)
	);

	// pack result fields from the lowest bit up
	assign m_axis_tdata = {6'b0, res.dropped, res.fill, data_byte};
	assign m_axis_tuser = res.byte_valid;
	assign m_axis_tlast = res.last;

endmodule

// File: sim/keypad_auto_repeat_fifo_core_test.sv
// self-checking bench for keypad_auto_repeat_fifo_core: queued requests, own fifo predictor
// depends on kar_pkg and the rtl under rtl; nothing else
`timescale 1ns / 1ps

module keypad_auto_repeat_fifo_core_test;

	import kar_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int MAX_PRINTED    = 40;

	// one request as the bench sees it
	typedef struct {
		op_e_t              op;
		logic [CODE_W-1:0]  levels;
		logic [RC_W-1:0]    count;
	} key_req_t;

	// one predicted result
	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              byte_valid;
		logic              last;
		logic [FILL_W-1:0] fill;
		logic              dropped;
	} key_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [7:0]       cfg_data = '0;

	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // switch_levels[2:0], read_count[9:3], zero pad
	logic [1:0]  s_axis_tuser = '0;   // op[1:0]

	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // data_byte[7:0], fill_level[16:8], dropped[17], zero pad
	logic        m_axis_tuser;        // byte_valid
	logic        m_axis_tlast;

	keypad_auto_repeat_fifo_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// request queue for the driver and results still owed by the block
	key_req_t pending_reqs[$];
	key_res_t results_due[$];
	key_req_t req_on_bus;

	// predictor state: byte fifo, typematic countdown and register shadows
	logic [BYTE_W-1:0]  byte_mem [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr = '0;
	logic [PTR_W-1:0]   rd_ptr = '0;
	int unsigned        held = 0;
	logic [CODE_W-1:0]  code_now = '0;
	logic [CODE_W-1:0]  code_seen = '0;
	logic [DELAY_W-1:0] ticks_to_go = LONG_RESET;
	logic [DELAY_W-1:0] long_dly = LONG_RESET;
	logic [DELAY_W-1:0] short_dly = SHORT_RESET;
	logic               rep_en = 1'b1;

	// idling knobs, percent of cycles
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// long receiver hold-off, armed once from the stimulus
	logic hold_arm = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;

	int errors = 0;
	int quiet_cycles = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
	endtask

	function automatic void add_due(input logic [BYTE_W-1:0] data, input logic bv,
			input logic last, input logic drop);
		key_res_t r;
		r.data = data;
		r.byte_valid = bv;
		r.last = last;
		r.fill = FILL_W'(held);
		r.dropped = drop;
		results_due.push_back(r);
	endfunction

	// push the current code as ascii; 0 when the fifo is full and the byte is lost
	function automatic logic store_code();
		if (held >= FIFO_DEPTH)
			return 1'b0;
		byte_mem[wr_ptr] = ASCII_ZERO + BYTE_W'(code_now);
		wr_ptr = (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
		held++;
		return 1'b1;
	endfunction

	// advance the keypad state by one request and queue the results it owes
	function automatic void keypad_step(input key_req_t r);
		logic        lost;
		int unsigned n;
		logic [BYTE_W-1:0] b;
		lost = 1'b0;
		case (r.op)
			OP_EDGE: begin
				code_now = ~r.levels;
				lost = !store_code();
				add_due('0, 1'b0, 1'b1, lost);
			end
			OP_TICK: begin
				if (rep_en) begin
					if (ticks_to_go <= 1) begin
						// expiry: a changed code only rearms with the long delay
						if (code_seen != code_now) begin
							ticks_to_go = long_dly;
						end else begin
							ticks_to_go = short_dly;
							if (code_now != '0)
								lost = !store_code();
						end
						code_seen = code_now;
					end else begin
						ticks_to_go--;
					end
				end
				add_due('0, 1'b0, 1'b1, lost);
			end
			OP_READ: begin
				n = r.count;
				if (n > MAX_READ)
					n = MAX_READ;
				if (n > held)
					n = held;
				if (n == 0) begin
					add_due('0, 1'b0, 1'b1, 1'b0);
				end else begin
					for (int k = 0; k < n; k++) begin
						b = byte_mem[rd_ptr];
						rd_ptr = (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
						held--;
						add_due(b, 1'b1, k == n - 1, 1'b0);
					end
				end
			end
			default: begin
				add_due('0, 1'b0, 1'b1, 1'b0);
			end
		endcase
	endfunction

	// request driver: predicts on acceptance, then offers the next queued request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				keypad_step(req_on_bus);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_on_bus = pending_reqs.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {6'b0, req_on_bus.count, req_on_bus.levels};
					s_axis_tuser <= req_on_bus.op;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// hold-off counter: once armed, keeps the result side stalled for a long stretch
	always @(posedge clk) begin
		if (hold_arm && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor: every accepted result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : result_check
		key_res_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (results_due.size() == 0) begin
					report("result with nothing pending", m_axis_tdata, '0);
				end else begin
					want = results_due.pop_front();
					if (m_axis_tdata[7:0] !== want.data)
						report("data_byte", m_axis_tdata[7:0], want.data);
					if (m_axis_tuser !== want.byte_valid)
						report("byte_valid", m_axis_tuser, want.byte_valid);
					if (m_axis_tlast !== want.last)
						report("last", m_axis_tlast, want.last);
					if (m_axis_tdata[16:8] !== want.fill)
						report("fill_level", m_axis_tdata[16:8], want.fill);
					if (m_axis_tdata[17] !== want.dropped)
						report("dropped", m_axis_tdata[17], want.dropped);
				end
			end
			m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: too long without any accepted request, result or register write
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic void add_req(input op_e_t op, input logic [CODE_W-1:0] lv,
			input logic [RC_W-1:0] cnt);
		key_req_t r;
		r.op = op;
		r.levels = lv;
		r.count = cnt;
		pending_reqs.push_back(r);
	endfunction

	// register write; only called while nothing is in flight
	task automatic cfg_write(input reg_idx_t idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_LONG_DELAY:    long_dly = val;
			REG_SHORT_DELAY:   short_dly = val;
			REG_REPEAT_ENABLE: rep_en = val[0];
			default: ;
		endcase
	endtask

	// wait until every queued request is taken and every result has come back
	task automatic settle();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || s_axis_tvalid || results_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// mostly keystrokes: press, hold over some ticks, maybe release, read back;
	// the rest is noise with any op, level and count
	task automatic queue_typing(input int n);
		int base;
		base = pending_reqs.size();
		while (pending_reqs.size() - base < n) begin
			if ($urandom_range(99) < 12) begin
				add_req(op_e_t'($urandom_range(3)), CODE_W'($urandom), RC_W'($urandom));
			end else begin
				add_req(OP_EDGE, CODE_W'($urandom), RC_W'($urandom));
				repeat ($urandom_range(1, 8))
					add_req(OP_TICK, CODE_W'($urandom), RC_W'($urandom));
				if ($urandom_range(1) == 1)
					add_req(OP_EDGE, 3'b111, RC_W'($urandom));
				add_req(OP_READ, CODE_W'($urandom), RC_W'($urandom_range(1, 24)));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// short delays so the directed part sees the countdown move
		cfg_write(REG_LONG_DELAY, 8'd2);
		cfg_write(REG_SHORT_DELAY, 8'd1);
		cfg_write(REG_REPEAT_ENABLE, 8'd1);
		@(negedge clk);

		// directed: empty read, every code, zero and oversized counts, unused op
		add_req(OP_READ, 3'b000, 7'd5);
		add_req(OP_EDGE, 3'b111, 7'd0);
		add_req(OP_EDGE, 3'b000, 7'd0);
		add_req(OP_EDGE, 3'b110, 7'd0);
		add_req(OP_EDGE, 3'b101, 7'd0);
		add_req(OP_EDGE, 3'b011, 7'd0);
		add_req(OP_READ, 3'b000, 7'd0);
		add_req(OP_READ, 3'b111, 7'd1);
		repeat (3) add_req(OP_TICK, 3'b000, 7'd0);
		add_req(OP_NONE, 3'b111, 7'd127);
		add_req(OP_READ, 3'b000, 7'd127);
		add_req(OP_READ, 3'b000, 7'd64);
		add_req(OP_EDGE, 3'b001, 7'd0);
		add_req(OP_EDGE, 3'b010, 7'd0);
		add_req(OP_EDGE, 3'b100, 7'd0);
		add_req(OP_READ, 3'b000, 7'd2);
		add_req(OP_READ, 3'b000, 7'd64);
		settle();

		// repeat: hold one key with the shortest delays, then change and release it
		cfg_write(REG_LONG_DELAY, 8'd1);
		cfg_write(REG_SHORT_DELAY, 8'd1);
		@(negedge clk);
		add_req(OP_EDGE, 3'b000, 7'd0);
		repeat (20) add_req(OP_TICK, 3'b000, 7'd0);
		repeat (3) add_req(OP_EDGE, CODE_W'($urandom), RC_W'($urandom));
		add_req(OP_EDGE, 3'b010, 7'd0);
		repeat (4) add_req(OP_TICK, 3'b000, 7'd0);
		// released key: expiries must not push a zero code
		add_req(OP_EDGE, 3'b111, 7'd0);
		repeat (4) add_req(OP_TICK, 3'b000, 7'd0);
		add_req(OP_READ, 3'b000, 7'd127);
		add_req(OP_READ, 3'b000, 7'd64);
		add_req(OP_READ, 3'b000, 7'd100);
		add_req(OP_READ, 3'b000, 7'd65);
		add_req(OP_READ, 3'b000, 7'd3);
		add_req(OP_READ, 3'b000, 7'd1);
		settle();

		// random, no idling
		cfg_write(REG_LONG_DELAY, 8'd3);
		cfg_write(REG_SHORT_DELAY, 8'd1);
		@(negedge clk);
		queue_typing(20);
		settle();

		// zero delays act like one; sender idles
		cfg_write(REG_LONG_DELAY, 8'd0);
		cfg_write(REG_SHORT_DELAY, 8'd0);
		@(negedge clk);
		send_idle_pct = 52;
		queue_typing(20);
		settle();

		// countdown frozen; receiver stalls and holds off long enough to back up the input
		cfg_write(REG_REPEAT_ENABLE, 8'd0);
		@(negedge clk);
		send_idle_pct = 0;
		recv_stall_pct = 52;
		hold_arm = 1'b1;
		queue_typing(25);
		settle();

		// largest delays; both sides idle
		cfg_write(REG_LONG_DELAY, 8'd255);
		cfg_write(REG_SHORT_DELAY, 8'd255);
		cfg_write(REG_REPEAT_ENABLE, 8'd1);
		@(negedge clk);
		send_idle_pct = 38;
		recv_stall_pct = 38;
		queue_typing(20);
		settle();

		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: files.f
rtl/kar_pkg.sv
rtl/kar_front.sv
rtl/kar_cmd_queue.sv
rtl/kar_back.sv
rtl/keypad_auto_repeat_fifo_core.sv
sim/keypad_auto_repeat_fifo_core_test.sv
